// File: rtl/core/wrrqp_pkg.sv
// ----------------------------------------------------------------------------
// wrrqp_pkg
// Shared types and constants of the weighted round-robin queue pick block.
// ----------------------------------------------------------------------------
package wrrqp_pkg;

    localparam int unsigned NUM_QUEUES = 4;
    localparam int unsigned QUEUE_W    = 2;
    localparam int unsigned WEIGHT_W   = 10;
    localparam int unsigned BUDGET_W   = 17;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [BUDGET_W-1:0] SOLE_BUDGET  = BUDGET_W'(100000);
    localparam logic [QUEUE_W-1:0]  TOP_QUEUE    = QUEUE_W'(3);
    localparam logic [BUDGET_W-1:0] RESET_BUDGET = BUDGET_W'(20);

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t [NUM_QUEUES-1:0] weight_vec_t;

    localparam weight_vec_t WEIGHT_RESET = {
        WEIGHT_W'(20), WEIGHT_W'(10), WEIGHT_W'(6), WEIGHT_W'(4)
    };

    typedef enum logic {
        CMD_SLICE_START = 1'b0,
        CMD_PICK        = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_Q0 = 2'd0,
        REG_WEIGHT_Q1 = 2'd1,
        REG_WEIGHT_Q2 = 2'd2,
        REG_WEIGHT_Q3 = 2'd3
    } reg_idx_t;

endpackage

// File: rtl/core/weighted_round_robin_queue_pick_top.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_queue_pick_top
// Weighted round-robin pick among four priority queues with per-queue weights.
// ----------------------------------------------------------------------------
// Each request is resolved in the cycle it is accepted: the downward search
// over the four queue flags, the budget reload and the decrement are one
// short combinational step from the current-queue and budget registers into
// the result register. One request is taken every cycle while the result
// side keeps up; the single output register lets a new request enter in the
// same cycle the waiting result is taken. The result is valid in the cycle
// after acceptance. Weight registers may be written only while
// no request is pending.
module weighted_round_robin_queue_pick_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [wrrqp_pkg::NUM_QUEUES-1:0]    s_queue_nonempty,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_granted,
    output logic [wrrqp_pkg::QUEUE_W-1:0]       m_grant_queue,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wrrqp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wrrqp_pkg::WEIGHT_W-1:0]      cfg_data
);
    import wrrqp_pkg::*;

    weight_vec_t           weight_reg;
    logic [QUEUE_W-1:0]    current_queue_reg, current_queue_next;
    logic [BUDGET_W-1:0]   budget_reg, budget_next;
    logic                  m_valid_reg;
    logic                  granted_reg, granted_next;
    logic [QUEUE_W-1:0]    grant_queue_reg, grant_queue_next;
    logic                  req_accept;

    assign req_accept    = s_valid && s_ready;
    assign s_ready       = aresetn && (!m_valid_reg || m_ready);
    assign cfg_ready     = aresetn;
    assign m_valid       = m_valid_reg;
    assign m_granted     = granted_reg;
    assign m_grant_queue = grant_queue_reg;

    always_comb begin
        logic [QUEUE_W-1:0]  q;
        logic [QUEUE_W-1:0]  cand;
        logic [QUEUE_W-1:0]  sel_q;
        logic                found;
        logic                sole;
        logic [BUDGET_W-1:0] load_budget;

        q                  = current_queue_reg;
        sel_q              = q;
        cand               = q;
        found              = 1'b0;
        sole               = 1'b0;
        load_budget        = budget_reg;
        current_queue_next = current_queue_reg;
        budget_next        = budget_reg;
        granted_next       = 1'b0;
        grant_queue_next   = '0;

        if (cmd_t'(s_cmd) == CMD_SLICE_START) begin
            current_queue_next = TOP_QUEUE;
            budget_next        = BUDGET_W'(weight_reg[TOP_QUEUE]);
        end else if (s_queue_nonempty[q] && (budget_reg != '0)) begin
            budget_next      = budget_reg - BUDGET_W'(1);
            granted_next     = 1'b1;
            grant_queue_next = q;
        end else begin
            // downward rotation, current queue last
            for (int i = 1; i <= NUM_QUEUES; i++) begin
                cand = q - QUEUE_W'(i);
                if (!found && s_queue_nonempty[cand]) begin
                    found = 1'b1;
                    sel_q = cand;
                    sole  = (i == NUM_QUEUES);
                end
            end
            if (found) begin
                load_budget        = sole ? SOLE_BUDGET : BUDGET_W'(weight_reg[sel_q]);
                current_queue_next = sel_q;
                budget_next        = (load_budget != '0) ? load_budget - BUDGET_W'(1)
                                                         : load_budget;
                granted_next       = 1'b1;
                grant_queue_next   = sel_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg        <= WEIGHT_RESET;
            current_queue_reg <= TOP_QUEUE;
            budget_reg        <= RESET_BUDGET;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                weight_reg[cfg_index] <= cfg_data;
            end
            if (req_accept) begin
                current_queue_reg <= current_queue_next;
                budget_reg        <= budget_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_accept) begin
            granted_reg     <= granted_next;
            grant_queue_reg <= grant_queue_next;
        end
    end

`ifndef SYNTHESIS
    a_budget_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        budget_reg <= SOLE_BUDGET)
        else $error("budget above sole queue budget");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        req_accept |=> m_valid)
        else $error("accepted request left no result");

    a_slice_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_accept && (cmd_t'(s_cmd) == CMD_SLICE_START))
        |=> (current_queue_reg == TOP_QUEUE) && !m_granted)
        else $error("slice start did not select top queue");

    a_no_grant_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_granted) |-> (m_grant_queue == '0))
        else $error("queue index set without grant");

    a_grant_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_accept && granted_next) |-> s_queue_nonempty[grant_queue_next])
        else $error("grant given to empty queue");
`endif

endmodule

// File: sim/weighted_round_robin_queue_pick_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_queue_pick_top_tb
// Self-checking bench for the weighted round-robin queue pick block.
// A stimulus table covers reset state, empty queues, slice starts and the
// sole-survivor budget, then random pick and slice requests run under
// several weight settings (minimum, maximum, zero and random). Every
// result is compared with a stated grant for known table rows, else with
// a local model of the arbiter. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module weighted_round_robin_queue_pick_top_tb;
    import wrrqp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_REQS  = 100;
    localparam int unsigned TABLE_ROWS  = 19;

    typedef struct packed {
        logic               granted;
        logic [QUEUE_W-1:0] queue;
    } grant_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [NUM_QUEUES-1:0] ne;
        logic                  known;
        logic                  granted;
        logic [QUEUE_W-1:0]    queue;
    } table_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [NUM_QUEUES-1:0] s_queue_nonempty;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_granted;
    logic [QUEUE_W-1:0]    m_grant_queue;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WEIGHT_W-1:0]   cfg_data;

    // arbiter model state
    weight_vec_t           weight_reg;
    logic [QUEUE_W-1:0]    cur_queue;
    logic [BUDGET_W-1:0]   budget;

    grant_t                grants_due[$];
    int unsigned           mismatches = 0;
    int unsigned           cycles = 0;
    bit                    s_idle;
    bit                    m_idle;

    // known rows follow from reset weights and state
    table_row_t stim_table [TABLE_ROWS] = '{
        '{CMD_PICK,        4'b0000, 1'b1, 1'b0, 2'd0},
        '{CMD_PICK,        4'b1111, 1'b1, 1'b1, 2'd3},
        '{CMD_SLICE_START, 4'b1010, 1'b1, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0001, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0001, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0001, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0001, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0001, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0011, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0010, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0110, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0100, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b1000, 1'b0, 1'b0, 2'd0},
        '{CMD_SLICE_START, 4'b0000, 1'b1, 1'b0, 2'd0},
        '{CMD_PICK,        4'b1111, 1'b0, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0000, 1'b1, 1'b0, 2'd0},
        '{CMD_PICK,        4'b1111, 1'b0, 1'b0, 2'd0},
        '{CMD_SLICE_START, 4'b1111, 1'b1, 1'b0, 2'd0},
        '{CMD_PICK,        4'b0111, 1'b0, 1'b0, 2'd0}
    };

    weighted_round_robin_queue_pick_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_queue_nonempty (s_queue_nonempty),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_grant_queue    (m_grant_queue),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic grant_t predict_grant(cmd_t cmd, logic [NUM_QUEUES-1:0] ne);
        grant_t             g;
        logic [QUEUE_W-1:0] q;
        int                 steps;
        bit                 found;
        g = '0;
        q = cur_queue;
        if (cmd == CMD_SLICE_START) begin
            cur_queue = TOP_QUEUE;
            budget    = BUDGET_W'(weight_reg[TOP_QUEUE]);
            return g;
        end
        if (!ne[q] || budget == '0) begin
            found = 1'b0;
            for (steps = 1; steps <= NUM_QUEUES; steps++) begin
                q = q - 1'b1;
                if (ne[q]) begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
                return g;
            cur_queue = q;
            // only the current queue left and out of budget
            budget = (steps == NUM_QUEUES) ? SOLE_BUDGET : BUDGET_W'(weight_reg[q]);
        end
        if (budget != '0)
            budget = budget - 1'b1;
        g.granted = 1'b1;
        g.queue   = q;
        return g;
    endfunction

    task automatic send_request(cmd_t cmd, logic [NUM_QUEUES-1:0] ne, logic known,
                                grant_t known_grant);
        int     gap;
        grant_t g;
        gap = s_idle ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_cmd            <= cmd;
        s_queue_nonempty <= ne;
        do @(posedge aclk); while (!s_ready);
        g = predict_grant(cmd, ne);
        grants_due.insert(grants_due.size(), known ? known_grant : g);
    endtask

    task automatic park_requests();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic load_weights(weight_vec_t w);
        int i;
        for (i = 0; i < NUM_QUEUES; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(i[CFG_IDX_W-1:0]);
            cfg_data  <= w[i];
            do @(posedge aclk); while (!cfg_ready);
            weight_reg[i] = w[i];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        int     stall;
        grant_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = m_idle ? $urandom_range(0, 5) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: granted=%0d queue=%0d",
                             m_granted, m_grant_queue);
            end else begin
                want = grants_due[0];
                grants_due.delete(0);
                if (m_granted !== want.granted || m_grant_queue !== want.queue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected granted=%0d queue=%0d",
                                 want.granted, want.queue,
                                 ", got granted=%0d queue=%0d",
                                 m_granted, m_grant_queue);
                end
            end
        end
    end

    initial begin
        int                    p;
        int                    n;
        int                    i;
        int                    zero_q;
        cmd_t                  cmd;
        logic [NUM_QUEUES-1:0] ne;
        weight_vec_t           w;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_cmd            = CMD_PICK;
        s_queue_nonempty = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_WEIGHT_Q0;
        cfg_data         = '0;
        s_idle           = 1'b1;
        m_idle           = 1'b1;
        weight_reg       = WEIGHT_RESET;
        cur_queue        = TOP_QUEUE;
        budget           = RESET_BUDGET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < TABLE_ROWS; n++)
            send_request(stim_table[n].cmd, stim_table[n].ne, stim_table[n].known,
                         {stim_table[n].granted, stim_table[n].queue});
        park_requests();

        for (p = 0; p < PHASES; p++) begin
            zero_q = $urandom_range(0, NUM_QUEUES - 1);
            for (i = 0; i < NUM_QUEUES; i++) begin
                case (p)
                    0: w[i] = WEIGHT_W'(1);
                    1: w[i] = {WEIGHT_W{1'b1}};
                    2: w[i] = (i == zero_q) ? '0 : WEIGHT_W'(i + 1);
                    default: w[i] = ($urandom_range(0, 7) == 0) ? {WEIGHT_W{1'b1}}
                                                                : WEIGHT_W'($urandom_range(1, 12));
                endcase
            end
            load_weights(w);
            s_idle = $urandom_range(0, 3) != 0;
            m_idle = $urandom_range(0, 3) != 0;
            ne = NUM_QUEUES'($urandom_range(0, 15));
            for (n = 0; n < PHASE_REQS; n++) begin
                cmd = ($urandom_range(0, 9) == 0) ? CMD_SLICE_START : CMD_PICK;
                // hold the queue flags for a while so budgets run out
                if ($urandom_range(0, 1) == 0)
                    ne = NUM_QUEUES'($urandom_range(0, 15));
                send_request(cmd, ne, 1'b0, '0);
            end
            park_requests();
        end

        repeat (4) @(posedge aclk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wrrqp_pkg.sv
rtl/core/weighted_round_robin_queue_pick_top.sv
sim/weighted_round_robin_queue_pick_top_tb.sv
